>>> hw/rtl/dqi_pkg.sv
// Shared constants for the indexed double-ended queue.
// Field widths, operation and status codes, default sizes.
// No dependencies.
package dqi_pkg;

  localparam int DEPTH_DEF      = 64;
  localparam int DATA_WIDTH_DEF = 32;

  localparam int KIND_W   = 3;
  localparam int POS_W    = 6;
  localparam int VALUE_W  = 32;
  localparam int DATA_W   = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 7;

  localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 3'd0;
  localparam logic [KIND_W-1:0] KIND_PUSH_TAIL  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_READ_IDX   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_WRITE_IDX  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_READ_FRONT = 3'd4;
  localparam logic [KIND_W-1:0] KIND_READ_BACK  = 3'd5;

  localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd3;

endpackage

>>> hw/rtl/dqi_cell.sv
// One storage cell of the rotating ring: takes its neighbor's word each cycle,
// or a new word when loaded.
// Depends on dqi_pkg for the default width.
module dqi_cell #(
  parameter int DATA_WIDTH = dqi_pkg::DATA_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  logic [DATA_WIDTH-1:0] shift_i,
  input  logic                  load_i,
  input  logic [DATA_WIDTH-1:0] load_data_i,
  output logic [DATA_WIDTH-1:0] word_o
);

  logic [DATA_WIDTH-1:0] word_q, word_d;

  assign word_d = load_i ? load_data_i : shift_i;

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign word_o = word_q;

endmodule

>>> hw/rtl/dqi_ring.sv
// Ring of dqi_cell instances that rotates by one entry every cycle.
// Cell 0 is the access port; a write enters at the last cell.
// Depends on dqi_pkg and dqi_cell.
module dqi_ring #(
  parameter int DEPTH      = dqi_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = dqi_pkg::DATA_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  wr_en_i,
  input  logic [DATA_WIDTH-1:0] wr_data_i,
  output logic [DATA_WIDTH-1:0] port_o
);

  logic [DATA_WIDTH-1:0] cell_word [DEPTH];

  // cell k holds the entry one ahead of cell k-1; the word leaving cell 0
  // wraps into the last cell unless it is overwritten there
  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    if (k == DEPTH - 1) begin : g_last
      dqi_cell #(.DATA_WIDTH(DATA_WIDTH)) u_cell (
        .clk_i      (clk_i),
        .shift_i    (cell_word[0]),
        .load_i     (wr_en_i),
        .load_data_i(wr_data_i),
        .word_o     (cell_word[k])
      );
    end else begin : g_mid
      dqi_cell #(.DATA_WIDTH(DATA_WIDTH)) u_cell (
        .clk_i      (clk_i),
        .shift_i    (cell_word[k+1]),
        .load_i     (1'b0),
        .load_data_i(wr_data_i),
        .word_o     (cell_word[k])
      );
    end
  end

  assign port_o = cell_word[0];

endmodule

>>> hw/rtl/double_ended_queue_indexed.sv
// Indexed double-ended queue on a rotating ring of storage cells.
// Refused or unused operations give their result in the cycle after the
// transfer; store accesses wait in addition for the ring rotation to bring the
// target entry to the access cell. One operation at a time.
// Reset clears head, count, rotation slot and handshake state; ring words are not cleared.
module double_ended_queue_indexed #(
  parameter int DEPTH      = dqi_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = dqi_pkg::DATA_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [dqi_pkg::KIND_W-1:0]    kind_i,
  input  logic [dqi_pkg::POS_W-1:0]     position_i,
  input  logic signed [dqi_pkg::VALUE_W-1:0] value_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [dqi_pkg::DATA_W-1:0]  data_o,
  output logic [dqi_pkg::STATUS_W-1:0]  status_o,
  output logic [dqi_pkg::COUNT_W-1:0]   count_o
);

  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int AW1  = AW + 1;
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int PW   = dqi_pkg::POS_W;
  localparam int XW   = (CW > PW) ? CW : PW;
  localparam int OW   = dqi_pkg::DATA_W;
  localparam int CNTW = dqi_pkg::COUNT_W;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SEEK = 1'b1;

  function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] h,
                                            input logic [AW-1:0] i);
    logic [AW:0] s;
    s = {1'b0, h} + {1'b0, i};
    if (s >= AW1'(DEPTH)) s = s - AW1'(DEPTH);
    return s[AW-1:0];
  endfunction

  logic                  state_q, state_d;
  logic [AW-1:0]         head_q, head_d;
  logic [CW-1:0]         count_q, count_d;
  logic [AW-1:0]         rot_q, rot_d;
  logic                  out_valid_q, out_valid_d;

  logic [AW-1:0]         tgt_q, tgt_d;
  logic                  op_wr_q, op_wr_d;
  logic [DATA_WIDTH-1:0] wdata_q, wdata_d;
  logic signed [OW-1:0]  out_data_q, out_data_d;
  logic [dqi_pkg::STATUS_W-1:0] out_status_q, out_status_d;
  logic [CNTW-1:0]       out_count_q, out_count_d;

  logic                  in_xfer, full, empty, range_err, match, ring_wr;
  logic [AW-1:0]         head_dec;
  logic [DATA_WIDTH-1:0] port_word;
  logic                  acc;
  logic                  acc_wr;
  logic [AW-1:0]         acc_tgt;
  logic [dqi_pkg::STATUS_W-1:0] imm_status;
  logic [CW-1:0]         acc_count;
  logic [AW-1:0]         acc_head;

  assign in_ready_o = (state_q == ST_IDLE) && (!out_valid_q || out_ready_i);
  assign in_xfer    = in_valid_i && in_ready_o;

  assign full      = (count_q == CW'(DEPTH));
  assign empty     = (count_q == '0);
  assign range_err = (XW'(position_i) >= XW'(count_q));
  assign head_dec  = (head_q == '0) ? AW'(DEPTH - 1) : head_q - 1'b1;
  assign match     = (rot_q == tgt_q);
  assign ring_wr   = (state_q == ST_SEEK) && match && op_wr_q;

  // decode of the incoming operation; pointers move at the transfer
  always_comb begin
    acc        = 1'b0;
    acc_wr     = 1'b0;
    acc_tgt    = head_q;
    imm_status = dqi_pkg::STAT_OK;
    acc_count  = count_q;
    acc_head   = head_q;
    unique case (kind_i)
      dqi_pkg::KIND_PUSH_FRONT: begin
        if (full) begin
          imm_status = dqi_pkg::STAT_FULL;
        end else begin
          acc       = 1'b1;
          acc_wr    = 1'b1;
          acc_tgt   = head_dec;
          acc_head  = head_dec;
          acc_count = count_q + 1'b1;
        end
      end
      dqi_pkg::KIND_PUSH_TAIL: begin
        if (full) begin
          imm_status = dqi_pkg::STAT_FULL;
        end else begin
          acc       = 1'b1;
          acc_wr    = 1'b1;
          acc_tgt   = slot_of(head_q, AW'(count_q));
          acc_count = count_q + 1'b1;
        end
      end
      dqi_pkg::KIND_READ_IDX: begin
        if (range_err) begin
          imm_status = dqi_pkg::STAT_RANGE;
        end else begin
          acc     = 1'b1;
          acc_tgt = slot_of(head_q, AW'(position_i));
        end
      end
      dqi_pkg::KIND_WRITE_IDX: begin
        if (range_err) begin
          imm_status = dqi_pkg::STAT_RANGE;
        end else begin
          acc     = 1'b1;
          acc_wr  = 1'b1;
          acc_tgt = slot_of(head_q, AW'(position_i));
        end
      end
      dqi_pkg::KIND_READ_FRONT: begin
        if (empty) begin
          imm_status = dqi_pkg::STAT_EMPTY;
        end else begin
          acc = 1'b1;
        end
      end
      dqi_pkg::KIND_READ_BACK: begin
        if (empty) begin
          imm_status = dqi_pkg::STAT_EMPTY;
        end else begin
          acc     = 1'b1;
          acc_tgt = slot_of(head_q, AW'(count_q - 1'b1));
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    state_d      = state_q;
    head_d       = head_q;
    count_d      = count_q;
    rot_d        = (rot_q == AW'(DEPTH - 1)) ? '0 : rot_q + 1'b1;
    out_valid_d  = out_valid_q && !out_ready_i;
    tgt_d        = tgt_q;
    op_wr_d      = op_wr_q;
    wdata_d      = wdata_q;
    out_data_d   = out_data_q;
    out_status_d = out_status_q;
    out_count_d  = out_count_q;
    if (in_xfer) begin
      head_d  = acc_head;
      count_d = acc_count;
      if (acc) begin
        state_d = ST_SEEK;
        tgt_d   = acc_tgt;
        op_wr_d = acc_wr;
        wdata_d = DATA_WIDTH'($unsigned(value_i));
      end else begin
        out_valid_d  = 1'b1;
        out_data_d   = '0;
        out_status_d = imm_status;
        out_count_d  = CNTW'(acc_count);
      end
    end else if (state_q == ST_SEEK && match) begin
      // cell 0 holds the target entry this cycle
      state_d      = ST_IDLE;
      out_valid_d  = 1'b1;
      out_data_d   = op_wr_q ? '0 : OW'(port_word);
      out_status_d = dqi_pkg::STAT_OK;
      out_count_d  = CNTW'(count_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      head_q      <= '0;
      count_q     <= '0;
      rot_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      count_q     <= count_d;
      rot_q       <= rot_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tgt_q        <= tgt_d;
    op_wr_q      <= op_wr_d;
    wdata_q      <= wdata_d;
    out_data_q   <= out_data_d;
    out_status_q <= out_status_d;
    out_count_q  <= out_count_d;
  end

  dqi_ring #(
    .DEPTH     (DEPTH),
    .DATA_WIDTH(DATA_WIDTH)
  ) u_ring (
    .clk_i    (clk_i),
    .wr_en_i  (ring_wr),
    .wr_data_i(wdata_q),
    .port_o   (port_word)
  );

  assign out_valid_o = out_valid_q;
  assign data_o      = out_data_q;
  assign status_o    = out_status_q;
  assign count_o     = out_count_q;

endmodule
